// File: hdl/dhd_pkg.sv
`timescale 1ns / 1ps

package dhd_pkg;

    localparam int CLASS_COUNT_DEF     = 4;
    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam int MAX_CLASSES         = 8;

    localparam logic [12:0] MAX_SRC = 13'd4096;

    localparam logic [2:0] REG_SCORE_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_MIN_AREA         = 3'd1;
    localparam logic [2:0] REG_PAD_LEFT         = 3'd2;
    localparam logic [2:0] REG_PAD_TOP          = 3'd3;
    localparam logic [2:0] REG_INVERSE_SCALE    = 3'd4;
    localparam logic [2:0] REG_SOURCE_WIDTH     = 3'd5;
    localparam logic [2:0] REG_SOURCE_HEIGHT    = 3'd6;
    localparam logic [2:0] REG_COLOUR_CLASS_IDS = 3'd7;

    localparam logic [1:0] COLOUR_GREEN   = 2'd0;
    localparam logic [1:0] COLOUR_RED     = 2'd1;
    localparam logic [1:0] COLOUR_YELLOW  = 2'd2;
    localparam logic [1:0] COLOUR_UNKNOWN = 2'd3;

    localparam logic [1:0] SHAPE_VERTICAL   = 2'd0;
    localparam logic [1:0] SHAPE_HORIZONTAL = 2'd1;
    localparam logic [1:0] SHAPE_QUADRATE   = 2'd2;

    typedef struct packed {
        logic [15:0] score_threshold;
        logic [23:0] min_area;
        logic [11:0] pad_left;
        logic [11:0] pad_top;
        logic [19:0] inverse_scale;
        logic [12:0] source_width;
        logic [12:0] source_height;
        logic [8:0]  colour_class_ids;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        score_threshold:  16'd32768,
        min_area:         24'd0,
        pad_left:         12'd0,
        pad_top:          12'd0,
        inverse_scale:    20'd65536,
        source_width:     13'd1920,
        source_height:    13'd1080,
        colour_class_ids: 9'd0
    };

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

endpackage

// File: hdl/dhd_best_class.sv
`timescale 1ns / 1ps

module dhd_best_class #(
    parameter int CLASS_COUNT = dhd_pkg::CLASS_COUNT_DEF
) (
    input  logic [dhd_pkg::MAX_CLASSES-1:0][15:0] scores,
    output logic [15:0]                           best,
    output logic [2:0]                            cls
);

    always_comb begin
        best = scores[0];
        cls  = '0;
        for (int i = 1; i < dhd_pkg::MAX_CLASSES; i++) begin
            if (i < CLASS_COUNT && scores[i] > best) begin
                best = scores[i];
                cls  = 3'(i);
            end
        end
    end

endmodule

// File: hdl/dhd_axis_lane.sv
`timescale 1ns / 1ps

module dhd_axis_lane #(
    parameter int COORD_FRAC_BITS = dhd_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  dhd_pkg::pipe_en_t en,
    input  logic [15:0]       center,
    input  logic [15:0]       size,
    input  logic [11:0]       pad,
    input  logic [19:0]       inv,
    input  logic [12:0]       lim,
    output logic [11:0]       org,
    output logic [12:0]       ext
);

    localparam int SH   = COORD_FRAC_BITS + 17;
    localparam int LO_W = ((COORD_FRAC_BITS + 14 > 17) ? COORD_FRAC_BITS + 14 : 17) + 2;
    localparam int PL_W = LO_W + 21;
    localparam int PS_W = 37;
    localparam int OR_W = PL_W - SH;
    localparam int E_W  = PS_W + 1 - SH;
    localparam int ES_W = ((OR_W > E_W + 1) ? OR_W : E_W + 1) + 1;
    localparam int CW   = ((ES_W > 14) ? ES_W : 14) + 1;
    localparam logic [PS_W:0] ROUND = (PS_W + 1)'((64'd1 << SH) - 64'd1);

    logic signed [LO_W-1:0] lo;
    logic signed [PL_W-1:0] prod_lo_reg, prod_lo_next;
    logic [PS_W-1:0]        prod_sz_reg, prod_sz_next;

    logic signed [OR_W-1:0] o_raw;
    logic [PS_W:0]          sz_round;
    logic [E_W-1:0]         e_raw;
    logic [OR_W-2:0]        o2_reg, o2_next;
    logic signed [ES_W-1:0] e2_reg, e2_next;

    logic signed [CW-1:0]   oc, ec, lc, sum, e3;
    logic [11:0]            org_reg, org_next;
    logic [12:0]            ext_reg, ext_next;

    // corners at one extra fraction bit, pad removed, scaled
    assign lo = $signed((LO_W'(center) << 1) - LO_W'(size)
                        - (LO_W'(pad) << (COORD_FRAC_BITS + 1)));
    assign prod_lo_next = PL_W'(lo) * PL_W'($signed({1'b0, inv}));
    assign prod_sz_next = PS_W'({size, 1'b0}) * PS_W'(inv);

    // floor origin, ceil extent, fold a negative origin into the extent
    assign o_raw    = $signed(prod_lo_reg[PL_W-1:SH]);
    assign sz_round = {1'b0, prod_sz_reg} + ROUND;
    assign e_raw    = sz_round[PS_W:SH];

    always_comb begin
        if (o_raw < 0) begin
            o2_next = '0;
            e2_next = ES_W'($signed({1'b0, e_raw})) + ES_W'(o_raw);
        end else begin
            o2_next = o_raw[OR_W-2:0];
            e2_next = ES_W'($signed({1'b0, e_raw}));
        end
    end

    // clip to the source extent
    assign oc  = CW'($signed({1'b0, o2_reg}));
    assign ec  = CW'(e2_reg);
    assign lc  = CW'($signed({1'b0, lim}));
    assign sum = oc + ec;

    always_comb begin
        e3       = '0;
        org_next = '0;
        ext_next = '0;
        if (oc < lc) begin
            e3 = (sum > lc) ? lc - oc : ec;
            if (e3 < 0) begin
                e3 = '0;
            end
            org_next = oc[11:0];
            ext_next = e3[12:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            prod_lo_reg <= prod_lo_next;
            prod_sz_reg <= prod_sz_next;
        end
        if (en.s2) begin
            o2_reg <= o2_next;
            e2_reg <= e2_next;
        end
        if (en.s3) begin
            org_reg <= org_next;
            ext_reg <= ext_next;
        end
    end

    assign org = org_reg;
    assign ext = ext_reg;

endmodule

// File: hdl/dhd_merge.sv
`timescale 1ns / 1ps

module dhd_merge (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [11:0]   x,
    input  logic [11:0]   y,
    input  logic [12:0]   w,
    input  logic [12:0]   h,
    input  logic [15:0]   best,
    input  logic [2:0]    cls,
    input  dhd_pkg::cfg_t cfg,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [71:0]   m_tdata
);

    logic        v4_reg, v4_next;
    logic [11:0] x4_reg, y4_reg;
    logic [12:0] w4_reg, h4_reg;
    logic [15:0] best4_reg;
    logic [25:0] area4_reg, area4_next;
    logic [1:0]  shape4_reg, shape4_next;
    logic [1:0]  colour4_reg, colour4_next;
    logic [13:0] w3, h3;
    logic        en_out, en4, pass;
    logic        m_valid_reg, m_valid_next;
    logic [71:0] m_data_reg, m_data_next;

    assign en_out   = !m_valid_reg || m_tready;
    assign en4      = !v4_reg || en_out;
    assign in_ready = en4;

    assign area4_next = 26'(w) * 26'(h);
    assign w3 = 14'(w) + (14'(w) << 1);
    assign h3 = 14'(h) + (14'(h) << 1);

    always_comb begin
        priority if (h > w3[13:1]) begin
            shape4_next = dhd_pkg::SHAPE_VERTICAL;
        end else if (w > h3[13:1]) begin
            shape4_next = dhd_pkg::SHAPE_HORIZONTAL;
        end else begin
            shape4_next = dhd_pkg::SHAPE_QUADRATE;
        end
    end

    always_comb begin
        priority if (cls == cfg.colour_class_ids[2:0]) begin
            colour4_next = dhd_pkg::COLOUR_GREEN;
        end else if (cls == cfg.colour_class_ids[5:3]) begin
            colour4_next = dhd_pkg::COLOUR_RED;
        end else if (cls == cfg.colour_class_ids[8:6]) begin
            colour4_next = dhd_pkg::COLOUR_YELLOW;
        end else begin
            colour4_next = dhd_pkg::COLOUR_UNKNOWN;
        end
    end

    assign v4_next = in_valid;

    // drop empty and undersized boxes
    assign pass         = (area4_reg != '0) && (area4_reg >= 26'(cfg.min_area));
    assign m_valid_next = v4_reg && pass;
    assign m_data_next  = {2'b00, shape4_reg, colour4_reg, best4_reg,
                           h4_reg, w4_reg, y4_reg, x4_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en4) begin
                v4_reg <= v4_next;
            end
            if (en_out) begin
                m_valid_reg <= m_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            x4_reg      <= x;
            y4_reg      <= y;
            w4_reg      <= w;
            h4_reg      <= h;
            best4_reg   <= best;
            area4_reg   <= area4_next;
            shape4_reg  <= shape4_next;
            colour4_reg <= colour4_next;
        end
        if (en_out) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: hdl/detection_head_decoder.sv
`timescale 1ns / 1ps

// Detection head decoder. Takes one prediction per cycle while no stall holds
// the pipeline, and delivers at most one decoded box per prediction. The
// pipeline stages are: best-class select with the corner and size multiplies,
// floor/ceil and origin fold, clip, area multiply with shape and colour coding,
// and the output register; two axis lanes (x and y) run side by side and the
// merge stage combines them. A stalled output only holds back the stages that
// are full, so bubbles left by dropped predictions are squeezed out. The user
// writes registers through the cfg port only while the block is idle; the block
// itself does not enforce this. There is no clearing pass after reset.
module detection_head_decoder #(
    parameter int CLASS_COUNT     = dhd_pkg::CLASS_COUNT_DEF,
    parameter int COORD_FRAC_BITS = dhd_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // center_x, center_y, box_w, box_h, score_0 .. score_7
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // box_left, box_top, box_width_out, box_height_out, winning score,
    // colour_code, shape_code, zero fill
    output logic [71:0]  m_tdata
);

    dhd_pkg::cfg_t     cfg_reg, cfg_next;
    dhd_pkg::pipe_en_t en;

    logic [dhd_pkg::MAX_CLASSES-1:0][15:0] scores;
    logic [15:0] best;
    logic [2:0]  cls;
    logic        keep;
    logic [12:0] lim_x, lim_y;

    logic        v1_reg, v2_reg, v3_reg;
    logic [15:0] best1_reg, best2_reg, best3_reg;
    logic [2:0]  cls1_reg, cls2_reg, cls3_reg;
    logic        en4;

    logic [11:0] org_x, org_y;
    logic [12:0] ext_x, ext_y;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                dhd_pkg::REG_SCORE_THRESHOLD:  cfg_next.score_threshold  = cfg_wdata[15:0];
                dhd_pkg::REG_MIN_AREA:         cfg_next.min_area         = cfg_wdata[23:0];
                dhd_pkg::REG_PAD_LEFT:         cfg_next.pad_left         = cfg_wdata[11:0];
                dhd_pkg::REG_PAD_TOP:          cfg_next.pad_top          = cfg_wdata[11:0];
                dhd_pkg::REG_INVERSE_SCALE:    cfg_next.inverse_scale    = cfg_wdata[19:0];
                dhd_pkg::REG_SOURCE_WIDTH:     cfg_next.source_width     = cfg_wdata[12:0];
                dhd_pkg::REG_SOURCE_HEIGHT:    cfg_next.source_height    = cfg_wdata[12:0];
                dhd_pkg::REG_COLOUR_CLASS_IDS: cfg_next.colour_class_ids = cfg_wdata[8:0];
            endcase
        end
    end

    assign lim_x = (cfg_reg.source_width > dhd_pkg::MAX_SRC) ?
                   dhd_pkg::MAX_SRC : cfg_reg.source_width;
    assign lim_y = (cfg_reg.source_height > dhd_pkg::MAX_SRC) ?
                   dhd_pkg::MAX_SRC : cfg_reg.source_height;

    assign en.s3    = !v3_reg || en4;
    assign en.s2    = !v2_reg || en.s3;
    assign en.s1    = !v1_reg || en.s2;
    assign s_tready = en.s1;

    assign scores = s_tdata[191:64];

    dhd_best_class #(
        .CLASS_COUNT(CLASS_COUNT)
    ) u_best (
        .scores(scores),
        .best  (best),
        .cls   (cls)
    );

    assign keep = best >= cfg_reg.score_threshold;

    dhd_axis_lane #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_lane_x (
        .aclk  (aclk),
        .en    (en),
        .center(s_tdata[15:0]),
        .size  (s_tdata[47:32]),
        .pad   (cfg_reg.pad_left),
        .inv   (cfg_reg.inverse_scale),
        .lim   (lim_x),
        .org   (org_x),
        .ext   (ext_x)
    );

    dhd_axis_lane #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_lane_y (
        .aclk  (aclk),
        .en    (en),
        .center(s_tdata[31:16]),
        .size  (s_tdata[63:48]),
        .pad   (cfg_reg.pad_top),
        .inv   (cfg_reg.inverse_scale),
        .lim   (lim_y),
        .org   (org_y),
        .ext   (ext_y)
    );

    dhd_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(v3_reg),
        .in_ready(en4),
        .x       (org_x),
        .y       (org_y),
        .w       (ext_x),
        .h       (ext_y),
        .best    (best3_reg),
        .cls     (cls3_reg),
        .cfg     (cfg_reg),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= dhd_pkg::CFG_RESET;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
            if (en.s1) begin
                v1_reg <= s_tvalid && keep;
            end
            if (en.s2) begin
                v2_reg <= v1_reg;
            end
            if (en.s3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            best1_reg <= best;
            cls1_reg  <= cls;
        end
        if (en.s2) begin
            best2_reg <= best1_reg;
            cls2_reg  <= cls1_reg;
        end
        if (en.s3) begin
            best3_reg <= best2_reg;
            cls3_reg  <= cls2_reg;
        end
    end

    a_box_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[36:24] != 13'd0) && (m_tdata[49:37] != 13'd0))
        else $error("empty box delivered");

    a_box_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (14'(m_tdata[11:0]) + 14'(m_tdata[36:24]) <= 14'd4096) &&
                     (14'(m_tdata[23:12]) + 14'(m_tdata[49:37]) <= 14'd4096))
        else $error("box reaches past the source limit");

    a_shape_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[69:68] != 2'd3))
        else $error("invalid shape code");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && !en4) |-> !s_tready)
        else $error("input taken while the pipeline is full and stalled");

endmodule
